// ----- src/ffsa_pkg.sv -----
// shared types and constants of the first-fit segment allocator
`default_nettype none

package ffsa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W       = 16;
  localparam int OWN_W        = 8;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [ADDR_W-1:0] HEAP_RESET = 16'd1024;

  // operation codes of the func field
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_HEAP_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_SPLIT,
    UPD_FREE_ONLY,
    UPD_FREE_LEFT,
    UPD_FREE_RIGHT,
    UPD_FREE_BOTH
  } upd_op_e;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              free;
    logic [OWN_W-1:0]  owner;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
  } seg_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic              init;
    logic [ADDR_W-1:0] init_len;
    logic              search;
    logic              func;
    logic [OWN_W-1:0]  tid;
    logic [ADDR_W-1:0] req;
    logic [ADDR_W-1:0] bstart;
    upd_op_e           op;
    logic [ADDR_W-1:0] upd_req;
    logic [OWN_W-1:0]  upd_tid;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- src/first_fit_segment_allocator.sv -----
// top level of the first-fit segment allocator with coalescing
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+----------------------------------------
// request  | in        | in_valid_i / in_ready_o | func_i thread_id_i request_size_i
//          |           |                         | block_start_i
// result   | out       | out_valid_o/out_ready_i | status_o address_o
// config   | in        | psel penable pwrite     | paddr pwdata prdata (heap_size at 0x0)
//
// in the accept cycle every cell compares its entry and a first-match ripple along the row
// picks the hit; in the update cycle the row shifts by one place on a split or by one or
// two places on a merge, and the result register loads
// the next item is taken in the cycle after the table update
// reset leaves one free segment of 1024 units, no clearing pass is needed
// a full result register stalls the update cycle until out_ready_i is seen
`default_nettype none

module first_fit_segment_allocator
  import ffsa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [OWN_W-1:0]     thread_id_i,
  input  logic [ADDR_W-1:0]    request_size_i,
  input  logic [ADDR_W-1:0]    block_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [ADDR_W-1:0]    address_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] heap_q;
  logic [CNT_W-1:0]  count_q;

  // request held for the update cycle
  upd_op_e           op_q;
  logic [ADDR_W-1:0] req_q;
  logic [OWN_W-1:0]  tid_q;
  status_e           pend_status_q;
  logic [ADDR_W-1:0] pend_addr_q;

  // result register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_addr_q;

  logic      accept, commit, cfg_we;
  cell_cmd_t cmd;

  seg_t                    seg [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] hit, hit_r, below_r, valid_vec;
  logic [MAX_SEGMENTS:0]   found;

  // search summary, computed in the accept cycle
  logic              any_hit, merge_left, merge_right;
  logic [ADDR_W-1:0] hit_start;
  upd_op_e           op_d;
  status_e           status_d;
  logic [ADDR_W-1:0] addr_d;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_HEAP_SIZE);
  assign prdata = (paddr[2] == REG_HEAP_SIZE) ? {{(PDATA_W - ADDR_W){1'b0}}, heap_q} : '0;

  // control sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_UPDATE: begin
        commit = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd.init     = cfg_we;
    cmd.init_len = pwdata[ADDR_W-1:0];
    cmd.search   = accept;
    cmd.func     = func_i;
    cmd.tid      = thread_id_i;
    cmd.req      = request_size_i;
    cmd.bstart   = block_start_i;
    cmd.op       = commit ? op_q : UPD_NONE;
    cmd.upd_req  = req_q;
    cmd.upd_tid  = tid_q;
  end

  // the row of cells
  assign found[0] = 1'b0;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    seg_t left_s, right1_s, right2_s;
    logic left_hit, left_below, right1_hit;

    if (i == 0) begin : g_left_edge
      assign left_s     = '0;
      assign left_hit   = 1'b0;
      assign left_below = 1'b0;
    end else begin : g_left
      assign left_s     = seg[i-1];
      assign left_hit   = hit_r[i-1];
      assign left_below = below_r[i-1];
    end

    if (i + 1 < MAX_SEGMENTS) begin : g_right1
      assign right1_s   = seg[i+1];
      assign right1_hit = hit_r[i+1];
    end else begin : g_right1_edge
      assign right1_s   = '0;
      assign right1_hit = 1'b0;
    end

    if (i + 2 < MAX_SEGMENTS) begin : g_right2
      assign right2_s = seg[i+2];
    end else begin : g_right2_edge
      assign right2_s = '0;
    end

    ffsa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .head_i       (i == 0),
      .cmd_i        (cmd),
      .left_i       (left_s),
      .left_hit_i   (left_hit),
      .left_below_i (left_below),
      .right1_i     (right1_s),
      .right2_i     (right2_s),
      .right1_hit_i (right1_hit),
      .found_i      (found[i]),
      .found_o      (found[i+1]),
      .hit_o        (hit[i]),
      .seg_o        (seg[i]),
      .hit_q_o      (hit_r[i]),
      .below_q_o    (below_r[i])
    );

    assign valid_vec[i] = seg[i].valid;
  end

  // neighbor flags of the hit entry and its start
  always_comb begin
    any_hit     = found[MAX_SEGMENTS];
    merge_left  = 1'b0;
    merge_right = 1'b0;
    hit_start   = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (hit[i]) begin
        hit_start = hit_start | seg[i].start;
      end
    end
    for (int i = 1; i < MAX_SEGMENTS; i++) begin
      merge_left = merge_left | (hit[i] & seg[i-1].free);
    end
    for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
      merge_right = merge_right | (hit[i] & seg[i+1].valid & seg[i+1].free);
    end
  end

  always_comb begin
    op_d     = UPD_NONE;
    status_d = ST_MISS;
    addr_d   = '0;
    if (func_i == FUNC_ALLOC) begin
      if (!any_hit) begin
        status_d = ST_MISS;
      end else if (count_q == CNT_W'(MAX_SEGMENTS)) begin
        // a fit exists but there is no room for the remainder
        status_d = ST_FULL;
      end else begin
        status_d = ST_OK;
        op_d     = UPD_SPLIT;
        addr_d   = hit_start;
      end
    end else if (any_hit) begin
      status_d = ST_OK;
      if (merge_left && merge_right) begin
        op_d = UPD_FREE_BOTH;
      end else if (merge_left) begin
        op_d = UPD_FREE_LEFT;
      end else if (merge_right) begin
        op_d = UPD_FREE_RIGHT;
      end else begin
        op_d = UPD_FREE_ONLY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_q      <= HEAP_RESET;
      count_q     <= CNT_W'(1);
      op_q        <= UPD_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        heap_q  <= pwdata[ADDR_W-1:0];
        count_q <= CNT_W'(1);
      end else if (commit) begin
        case (op_q)
          UPD_SPLIT:      count_q <= count_q + CNT_W'(1);
          UPD_FREE_LEFT:  count_q <= count_q - CNT_W'(1);
          UPD_FREE_RIGHT: count_q <= count_q - CNT_W'(1);
          UPD_FREE_BOTH:  count_q <= count_q - CNT_W'(2);
          default:        count_q <= count_q;
        endcase
      end
      if (accept) begin
        op_q <= op_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q         <= request_size_i;
      tid_q         <= thread_id_i;
      pend_status_q <= status_d;
      pend_addr_q   <= addr_d;
    end
    if (commit) begin
      out_status_q <= pend_status_q;
      out_addr_q   <= pend_addr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign address_o   = out_addr_q;

  // live entries always form a prefix of the row and match the count
  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + MAX_SEGMENTS'(1)) & valid_vec) == '0)
    else $error("live entries are not contiguous");

  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("segment count disagrees with live entries");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> $onehot0(hit))
    else $error("more than one cell claims the hit");

  a_commit_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && (state_q == S_IDLE))
    else $error("table update without a result");

  a_head_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_vec[0])
    else $error("first segment lost");

endmodule

`default_nettype wire

// ----- src/ffsa_cell.sv -----
// one segment cell: holds a table entry, matches it, shifts with its neighbors
`default_nettype none

module ffsa_cell
  import ffsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_i,
  input  cell_cmd_t cmd_i,
  input  seg_t      left_i,
  input  logic      left_hit_i,
  input  logic      left_below_i,
  input  seg_t      right1_i,
  input  seg_t      right2_i,
  input  logic      right1_hit_i,
  input  logic      found_i,
  output logic      found_o,
  output logic      hit_o,
  output seg_t      seg_o,
  output logic      hit_q_o,
  output logic      below_q_o
);

  seg_t seg_q, seg_d;
  logic hit_q, below_q;
  logic match;

  always_comb begin
    if (cmd_i.func == FUNC_ALLOC) begin
      match = seg_q.valid && seg_q.free && (cmd_i.req != '0) && (seg_q.length > cmd_i.req);
    end else begin
      match = seg_q.valid && !seg_q.free && (seg_q.owner == cmd_i.tid) &&
              (seg_q.start == cmd_i.bstart);
    end
  end

  // first-match ripple along the row
  assign found_o = found_i | match;
  assign hit_o   = match & ~found_i;

  always_comb begin
    seg_d = seg_q;
    if (cmd_i.init) begin
      seg_d.valid  = head_i;
      seg_d.free   = head_i;
      seg_d.owner  = '0;
      seg_d.start  = '0;
      seg_d.length = head_i ? cmd_i.init_len : '0;
    end else begin
      case (cmd_i.op)
        UPD_SPLIT: begin
          if (hit_q) begin
            seg_d.length = cmd_i.upd_req;
            seg_d.owner  = cmd_i.upd_tid;
            seg_d.free   = 1'b0;
          end else if (left_hit_i) begin
            // remainder of the split segment
            seg_d.valid  = 1'b1;
            seg_d.free   = left_i.free;
            seg_d.owner  = '0;
            seg_d.start  = left_i.start + cmd_i.upd_req;
            seg_d.length = left_i.length - cmd_i.upd_req;
          end else if (left_below_i) begin
            seg_d = left_i;
          end
        end
        UPD_FREE_ONLY: begin
          if (hit_q) begin
            seg_d.free  = 1'b1;
            seg_d.owner = '0;
          end
        end
        UPD_FREE_LEFT: begin
          if (right1_hit_i) begin
            seg_d.length = seg_q.length + right1_i.length;
          end else if (hit_q || below_q) begin
            seg_d = right1_i;
          end
        end
        UPD_FREE_RIGHT: begin
          if (hit_q) begin
            seg_d.length = seg_q.length + right1_i.length;
            seg_d.free   = 1'b1;
            seg_d.owner  = '0;
          end else if (below_q) begin
            seg_d = right1_i;
          end
        end
        UPD_FREE_BOTH: begin
          if (right1_hit_i) begin
            seg_d.length = seg_q.length + right1_i.length + right2_i.length;
          end else if (hit_q || below_q) begin
            seg_d = right2_i;
          end
        end
        default: begin
          seg_d = seg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q.valid  <= head_i;
      seg_q.free   <= head_i;
      seg_q.owner  <= '0;
      seg_q.start  <= '0;
      seg_q.length <= head_i ? HEAP_RESET : '0;
      hit_q        <= 1'b0;
      below_q      <= 1'b0;
    end else begin
      seg_q <= seg_d;
      if (cmd_i.search) begin
        hit_q   <= hit_o;
        below_q <= found_i;
      end
    end
  end

  assign seg_o     = seg_q;
  assign hit_q_o   = hit_q;
  assign below_q_o = below_q;

endmodule

`default_nettype wire

// ----- bench/segment_table_sb_pkg.sv -----
// scoreboard class: segment table predictor and queue of expected allocator results
package segment_table_sb_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import ffsa_pkg::*;

  typedef struct {
    status_e           status;
    logic [ADDR_W-1:0] address;
  } alloc_result_t;

  class segment_table_sb;
    logic [ADDR_W-1:0] heap_units;
    logic [ADDR_W-1:0] seg_base [MAX_SEGMENTS];
    logic [ADDR_W-1:0] seg_len  [MAX_SEGMENTS];
    logic [OWN_W-1:0]  seg_tid  [MAX_SEGMENTS];
    bit                seg_open [MAX_SEGMENTS];
    int                n_segs;
    alloc_result_t     pending_results [$];
    int                n_checked;
    int                mismatches;

    function new();
      heap_units = HEAP_RESET;
      n_checked  = 0;
      mismatches = 0;
      rebuild();
    endfunction

    // one free segment covering the whole heap
    function void rebuild();
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        seg_base[i] = '0;
        seg_len[i]  = '0;
        seg_tid[i]  = '0;
        seg_open[i] = 1'b0;
      end
      seg_len[0]  = heap_units;
      seg_open[0] = 1'b1;
      n_segs      = 1;
    endfunction

    function void load_heap(logic [PDATA_W-1:0] value);
      heap_units = value[ADDR_W-1:0];
      rebuild();
    endfunction

    // close the gap of k entries at pos
    function void drop_entries(int pos, int k);
      for (int i = pos; i + k < n_segs; i++) begin
        seg_base[i] = seg_base[i+k];
        seg_len[i]  = seg_len[i+k];
        seg_tid[i]  = seg_tid[i+k];
        seg_open[i] = seg_open[i+k];
      end
      for (int i = n_segs - k; i < n_segs; i++) begin
        seg_base[i] = '0;
        seg_len[i]  = '0;
        seg_tid[i]  = '0;
        seg_open[i] = 1'b0;
      end
      n_segs -= k;
    endfunction

    function status_e carve(logic [OWN_W-1:0] tid, logic [ADDR_W-1:0] req,
                            output logic [ADDR_W-1:0] addr);
      int hit;
      hit  = n_segs;
      addr = '0;
      if (req == '0) return ST_MISS;
      for (int i = 0; i < n_segs; i++) begin
        if (seg_open[i] && seg_len[i] > req) begin
          hit = i;
          break;
        end
      end
      if (hit >= n_segs) return ST_MISS;
      if (n_segs >= MAX_SEGMENTS) return ST_FULL;
      for (int i = n_segs; i > hit; i--) begin
        seg_base[i] = seg_base[i-1];
        seg_len[i]  = seg_len[i-1];
        seg_tid[i]  = seg_tid[i-1];
        seg_open[i] = seg_open[i-1];
      end
      n_segs++;
      // low part is handed out, the rest stays free
      seg_len[hit]    = req;
      seg_tid[hit]    = tid;
      seg_open[hit]   = 1'b0;
      seg_base[hit+1] = seg_base[hit+1] + req;
      seg_len[hit+1]  = seg_len[hit+1] - req;
      seg_tid[hit+1]  = '0;
      addr = seg_base[hit];
      return ST_OK;
    endfunction

    function status_e return_block(logic [OWN_W-1:0] tid, logic [ADDR_W-1:0] start);
      int hit;
      bit left_open;
      bit right_open;
      hit = n_segs;
      for (int i = 0; i < n_segs; i++) begin
        if (!seg_open[i] && seg_tid[i] == tid && seg_base[i] == start) begin
          hit = i;
          break;
        end
      end
      if (hit >= n_segs) return ST_MISS;
      left_open  = hit > 0 && seg_open[hit-1];
      right_open = hit + 1 < n_segs && seg_open[hit+1];
      if (left_open && right_open) begin
        seg_len[hit-1] = seg_len[hit-1] + seg_len[hit] + seg_len[hit+1];
        drop_entries(hit, 2);
      end else if (left_open) begin
        seg_len[hit-1] = seg_len[hit-1] + seg_len[hit];
        drop_entries(hit, 1);
      end else if (right_open) begin
        seg_len[hit]  = seg_len[hit] + seg_len[hit+1];
        seg_open[hit] = 1'b1;
        seg_tid[hit]  = '0;
        drop_entries(hit + 1, 1);
      end else begin
        seg_open[hit] = 1'b1;
        seg_tid[hit]  = '0;
      end
      return ST_OK;
    endfunction

    // an accepted request updates the table and queues its result
    function void note_request(logic func, logic [OWN_W-1:0] tid,
                               logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] bstart);
      alloc_result_t     r;
      logic [ADDR_W-1:0] addr;
      addr = '0;
      if (func == FUNC_ALLOC) r.status = carve(tid, req, addr);
      else r.status = return_block(tid, bstart);
      r.address = addr;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t mismatch on result %0d: %s", $time, n_checked, msg);
      mismatches++;
    endtask

    task check_result(logic [1:0] status, logic [ADDR_W-1:0] address);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
      if (address !== want.address)
        report($sformatf("address %0d, expected %0d", address, want.address));
      n_checked++;
    endtask

    function int pending();
      return pending_results.size();
    endfunction

    function int used();
      return n_segs;
    endfunction

    // a live allocation, left untouched when there is none
    function bit pick_owned(inout logic [OWN_W-1:0] tid, inout logic [ADDR_W-1:0] start);
      int idx [$];
      int k;
      for (int i = 0; i < n_segs; i++)
        if (!seg_open[i]) idx.push_back(i);
      if (idx.size() == 0) return 1'b0;
      k     = idx[$urandom_range(0, idx.size() - 1)];
      tid   = seg_tid[k];
      start = seg_base[k];
      return 1'b1;
    endfunction

    function void pick_any(inout logic [OWN_W-1:0] tid, inout logic [ADDR_W-1:0] start);
      int k;
      k     = $urandom_range(0, n_segs - 1);
      tid   = seg_tid[k];
      start = seg_base[k];
    endfunction

    function logic [ADDR_W-1:0] largest_free();
      logic [ADDR_W-1:0] best;
      best = '0;
      for (int i = 0; i < n_segs; i++)
        if (seg_open[i] && seg_len[i] > best) best = seg_len[i];
      return best;
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
// top-level testbench of the first-fit segment allocator
module tb_top
  import ffsa_pkg::*, segment_table_sb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_RESULT = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // register byte addresses: heap_size at index 0, the next index is unmapped
  localparam logic [PADDR_W-1:0] HEAP_SIZE_ADDR = {REG_HEAP_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR     = {~REG_HEAP_SIZE, 2'b00};

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                func_i         = FUNC_ALLOC;
  logic [OWN_W-1:0]    thread_id_i    = '0;
  logic [ADDR_W-1:0]   request_size_i = '0;
  logic [ADDR_W-1:0]   block_start_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [1:0]          status_o;
  logic [ADDR_W-1:0]   address_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [PDATA_W-1:0]  pwdata         = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  segment_table_sb sb;
  int              n_results   = 0;
  int              quiet_cycles = 0;
  bit              send_calm   = 1'b0;

  first_fit_segment_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .thread_id_i    (thread_id_i),
    .request_size_i (request_size_i),
    .block_start_i  (block_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .address_o      (address_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // idle stretch length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // any 16-bit value
  function automatic logic [ADDR_W-1:0] rand_word();
    return ADDR_W'($urandom_range(0, 65535));
  endfunction

  // offer one item, hold it until taken, then feed the predictor
  task automatic send_request(input logic func, input logic [OWN_W-1:0] tid,
                              input logic [ADDR_W-1:0] req, input logic [ADDR_W-1:0] bstart);
    int gap;
    gap = (!send_calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if ($urandom_range(0, 99) < 3) send_calm = !send_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    thread_id_i    <= tid;
    request_size_i <= req;
    block_start_i  <= bstart;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(func, tid, req, bstart);
  endtask

  // drop valid and wait until every outstanding result has drained
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup cycle, then access cycle; pready is always high so the write lands
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_HEAP_SIZE) sb.load_heap(data);
  endtask

  // directed part on the reset heap of 1024 units
  task automatic directed_requests();
    // zero request, exact fit of the whole heap, oversize request
    send_request(FUNC_ALLOC, 8'h5A, 16'd0, rand_word());
    send_request(FUNC_ALLOC, 8'h01, HEAP_RESET, rand_word());
    send_request(FUNC_ALLOC, 8'hC3, 16'hFFFF, 16'hFFFF);
    // unit block at 0, then 100 units at 1
    send_request(FUNC_ALLOC, 8'hFF, 16'd1, rand_word());
    send_request(FUNC_ALLOC, 8'h00, 16'd100, rand_word());
    // free of the free tail, then free with a wrong owner
    send_request(FUNC_FREE, 8'h00, rand_word(), 16'd101);
    send_request(FUNC_FREE, 8'h07, rand_word(), 16'd0);
    // thirteen unit blocks at 101 upward fill the table
    for (int k = 1; k <= 13; k++)
      send_request(FUNC_ALLOC, 8'(k), 16'd1, rand_word());
    // table full, then a failed search while full
    send_request(FUNC_ALLOC, 8'h80, 16'd1, rand_word());
    send_request(FUNC_ALLOC, 8'h81, 16'd5000, rand_word());
    // no free neighbour, right merge, left merge, none again, both sides
    send_request(FUNC_FREE, 8'h00, rand_word(), 16'd1);
    send_request(FUNC_FREE, 8'hFF, rand_word(), 16'd0);
    send_request(FUNC_FREE, 8'h01, rand_word(), 16'd101);
    send_request(FUNC_FREE, 8'h03, rand_word(), 16'd103);
    send_request(FUNC_FREE, 8'h02, rand_word(), 16'd102);
  endtask

  // mostly well-formed allocate/free traffic, some malformed frees and noise
  task automatic random_requests(input int count);
    logic              func;
    logic [OWN_W-1:0]  tid;
    logic [ADDR_W-1:0] req;
    logic [ADDR_W-1:0] bstart;
    int                roll;
    int                free_share;
    int                top;
    int                cap;
    repeat (count) begin
      // lean toward frees when the table runs nearly full
      free_share = (sb.used() >= MAX_SEGMENTS - 4) ? 60 : 35;
      roll   = $urandom_range(0, 99);
      func   = FUNC_ALLOC;
      tid    = OWN_W'($urandom_range(0, 255));
      req    = rand_word();
      bstart = rand_word();
      if (roll < free_share) begin
        func = FUNC_FREE;
        void'(sb.pick_owned(tid, bstart));
      end else if (roll < free_share + 10) begin
        func = FUNC_FREE;
        case ($urandom_range(0, 3))
          0: begin
            if (sb.pick_owned(tid, bstart)) tid = tid ^ 8'h01;
          end
          1: begin
            if (sb.pick_owned(tid, bstart)) bstart = bstart + 16'd1;
          end
          2: sb.pick_any(tid, bstart);
          default: begin
            func = FUNC_ALLOC;
            req  = '0;
          end
        endcase
      end else begin
        top  = int'(sb.heap_units);
        cap  = (top / 8 > 1) ? top / 8 : 1;
        roll = $urandom_range(0, 99);
        if (roll < 65) req = ADDR_W'($urandom_range(1, cap));
        else if (roll < 80) req = ADDR_W'($urandom_range(1, (top > 1) ? top : 1));
        else if (roll < 92) begin
          // just fits, or an exact fit that must be refused
          req = sb.largest_free();
          if ($urandom_range(0, 1) == 1) req = req - 16'd1;
        end
      end
      send_request(func, tid, req, bstart);
    end
  endtask

  // result side: random stalls with calm stretches, one long hold-off
  initial begin : sink
    int stall_left;
    bit calm;
    bit long_hold_done;
    stall_left     = 0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) calm = !calm;
      // hold off long enough for the request side to back up
      if (!long_hold_done && n_results >= HOLD_AT_RESULT) begin
        stall_left     = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // every taken result is compared with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(status_o, address_o);
      n_results++;
    end
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset heap of 1024 units
    directed_requests();
    random_requests(450);

    // one-unit heap: nothing ever fits
    settle();
    apb_write(HEAP_SIZE_ADDR, 32'd1);
    random_requests(50);

    // largest heap
    settle();
    apb_write(HEAP_SIZE_ADDR, 32'h0000_FFFF);
    random_requests(350);

    // zero heap: every allocate misses
    settle();
    apb_write(HEAP_SIZE_ADDR, 32'd0);
    random_requests(40);

    // upper data bits are dropped, heap becomes 300
    settle();
    apb_write(HEAP_SIZE_ADDR, 32'hABCD_012C);
    random_requests(300);

    // write to the unmapped index leaves the table alone
    settle();
    apb_write(SPARE_ADDR, 32'h0000_0005);
    random_requests(250);

    settle();
    apb_write(HEAP_SIZE_ADDR, 32'd2048);
    random_requests(300);

    settle();
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
